// ===== hdl/keyed_max_priority_table_macros.svh =====
// Assertion macros for the checker file.
`ifndef KEYED_MAX_PRIORITY_TABLE_MACROS_SVH
`define KEYED_MAX_PRIORITY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmpt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KMPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmpt assertion failed");

`endif

// ===== hdl/kmpt_pkg.sv =====
// Shared constants and types of the keyed max-priority table.
package kmpt_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int LVL_W    = 16;
    localparam int ARR_W    = 32;
    localparam int STATUS_W = 3;

    localparam int KMPT_ENTRIES = 64;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_INCREASE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [LVL_W-1:0] level;
        logic [ARR_W-1:0] arrival;
    } t_slot;

endpackage

// ===== hdl/kmpt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module kmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/keyed_max_priority_table.sv =====
// Keyed max-priority table: insert, increase, remove and query over one slot RAM.
// An accepted transaction runs S_SCAN, then S_FIN decides and registers the
// result strobe; busy stays high until idle, so no new one is taken before then.
// Each sweeps every slot through the single RAM read port (one read per cycle) and
// writes back at most once. Reset (synchronous, active low) clears the arrival
// counter, then clears every RAM slot with busy high; results cannot be stalled.
module keyed_max_priority_table #(
    parameter int ENTRIES = kmpt_pkg::KMPT_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kmpt_pkg::OP_W-1:0]     i_operation,
    input  logic [kmpt_pkg::KEY_W-1:0]    i_entry_id,
    input  logic [kmpt_pkg::LVL_W-1:0]    i_amount,
    output logic                          o_valid,
    output logic [kmpt_pkg::STATUS_W-1:0] o_status,
    output logic [kmpt_pkg::KEY_W-1:0]    o_result_id,
    output logic [kmpt_pkg::LVL_W-1:0]    o_result_level
);
    import kmpt_pkg::*;

    localparam int            IW   = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Controller states
    localparam logic [1:0] S_CLEAR = 2'd0;  // post-reset RAM sweep
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;  // one slot read per cycle
    localparam logic [1:0] S_FIN   = 2'd3;  // decide, write back, report

    logic [1:0]          r_state, n_state;
    logic [IW-1:0]       r_addr, n_addr;       // read issue / clear address
    logic                r_issue, n_issue;     // reads still to issue
    logic                r_rd_vld, n_rd_vld;   // RAM data valid this cycle
    logic [IW-1:0]       r_rd_idx, n_rd_idx;   // slot index of RAM data

    // Latched transaction
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [LVL_W-1:0]    r_amt, n_amt;

    // Scan results
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_hit_idx, n_hit_idx;
    logic [LVL_W-1:0]    r_hit_lvl, n_hit_lvl;
    logic [ARR_W-1:0]    r_hit_arr, n_hit_arr;
    logic                r_free, n_free;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic                r_best, n_best;
    logic [KEY_W-1:0]    r_best_key, n_best_key;
    logic [LVL_W-1:0]    r_best_lvl, n_best_lvl;
    logic [ARR_W-1:0]    r_best_arr, n_best_arr;

    logic [ARR_W-1:0]    r_arr_cnt, n_arr_cnt;

    // Result register
    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [KEY_W-1:0]    r_o_id, n_o_id;
    logic [LVL_W-1:0]    r_o_lvl, n_o_lvl;

    // RAM interface
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_slot               ram_wdata;
    t_slot               ram_rdata;
    logic [LVL_W:0]      sat_sum;
    logic                accept;

    kmpt_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Busy also covers the reset cycle itself, so nothing is taken during reset.
    assign busy   = (r_state != S_IDLE) || !i_rst_n;
    assign accept = start && !busy;

    // Saturating level add for increase
    assign sat_sum = {1'b0, r_hit_lvl} + {1'b0, r_amt};

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_op       = r_op;
        n_key      = r_key;
        n_amt      = r_amt;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_lvl  = r_hit_lvl;
        n_hit_arr  = r_hit_arr;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_best     = r_best;
        n_best_key = r_best_key;
        n_best_lvl = r_best_lvl;
        n_best_arr = r_best_arr;
        n_arr_cnt  = r_arr_cnt;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_lvl    = r_o_lvl;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_op    = i_operation;
                    n_key   = i_entry_id;
                    n_amt   = i_amount;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_best  = 1'b0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // Issue side
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // Data side: read data for the slot issued in the previous cycle
                if (r_rd_vld) begin
                    if (ram_rdata.valid) begin
                        if (ram_rdata.key == r_key && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_rd_idx;
                            n_hit_lvl = ram_rdata.level;
                            n_hit_arr = ram_rdata.arrival;
                        end
                        if (!r_best || ram_rdata.level > r_best_lvl ||
                            (ram_rdata.level == r_best_lvl &&
                             ram_rdata.arrival < r_best_arr)) begin
                            n_best     = 1'b1;
                            n_best_key = ram_rdata.key;
                            n_best_lvl = ram_rdata.level;
                            n_best_arr = ram_rdata.arrival;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                    if (r_rd_idx == LAST) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                n_o_valid  = 1'b1;
                n_o_status = ST_OK;
                n_o_id     = '0;
                n_o_lvl    = '0;
                n_addr     = '0;
                n_state    = S_IDLE;
                case (r_op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            n_o_status = ST_DUPLICATE;
                        end else if (!r_free) begin
                            n_o_status = ST_FULL;
                        end else begin
                            ram_we            = 1'b1;
                            ram_waddr         = r_free_idx;
                            ram_wdata.valid   = 1'b1;
                            ram_wdata.key     = r_key;
                            ram_wdata.level   = r_amt;
                            ram_wdata.arrival = r_arr_cnt;
                            n_arr_cnt         = r_arr_cnt + 1'b1;
                        end
                    end
                    OP_INCREASE: begin
                        if (!r_hit) begin
                            n_o_status = ST_NOT_FOUND;
                        end else begin
                            ram_we            = 1'b1;
                            ram_waddr         = r_hit_idx;
                            ram_wdata.valid   = 1'b1;
                            ram_wdata.key     = r_key;
                            ram_wdata.level   = sat_sum[LVL_W] ? '1 : sat_sum[LVL_W-1:0];
                            ram_wdata.arrival = r_hit_arr;
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_hit) begin
                            n_o_status = ST_NOT_FOUND;
                        end else begin
                            // Dropping the valid bit frees the slot
                            ram_we    = 1'b1;
                            ram_waddr = r_hit_idx;
                        end
                    end
                    default: begin
                        // Query has no side effects
                        if (!r_best) begin
                            n_o_status = ST_EMPTY;
                        end else begin
                            n_o_id  = r_best_key;
                            n_o_lvl = r_best_lvl;
                        end
                    end
                endcase
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_arr_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_issue   <= n_issue;
            r_rd_vld  <= n_rd_vld;
            r_arr_cnt <= n_arr_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_op       <= n_op;
        r_key      <= n_key;
        r_amt      <= n_amt;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_lvl  <= n_hit_lvl;
        r_hit_arr  <= n_hit_arr;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_best_lvl <= n_best_lvl;
        r_best_arr <= n_best_arr;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_lvl    <= n_o_lvl;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_id    = r_o_id;
    assign o_result_level = r_o_lvl;
endmodule

// ===== hdl/kmpt_checker.sv =====
// Port-level checker for the keyed max-priority table, bound to the top level.
`include "keyed_max_priority_table_macros.svh"

module kmpt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [kmpt_pkg::STATUS_W-1:0] o_status,
    input logic [kmpt_pkg::KEY_W-1:0]    o_result_id,
    input logic [kmpt_pkg::LVL_W-1:0]    o_result_level
);
    import kmpt_pkg::*;

    // A taken transaction keeps the block busy in the following cycle
    `KMPT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // Results are single-cycle strobes
    `KMPT_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // Only defined status codes are reported
    `KMPT_ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_valid, o_status <= ST_DUPLICATE)
    // Failed results carry zero payload
    `KMPT_ASSERT_IMP(a_zero_payload, i_clk, i_rst_n, o_valid && o_status != ST_OK,
                     o_result_id == '0 && o_result_level == '0)
endmodule

bind keyed_max_priority_table kmpt_checker u_kmpt_checker (.*);

// ===== test/keyed_max_priority_table_tb.sv =====
// Self-checking testbench for the keyed max-priority table: directed corners, then random traffic.
module keyed_max_priority_table_tb;
    import kmpt_pkg::*;

    localparam int DEPTH       = KMPT_ENTRIES;
    localparam int LATENCY     = DEPTH + 3;     // start accept to result strobe
    localparam int MAX_GAP     = 90;            // longest sender idle stretch, in cycles
    localparam int POOL_SIZE   = 96;            // more ids than slots, so the table can fill
    localparam int MAX_REPORTS = 10;

    // One expected result: what the table must answer for one transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    id;
        logic [LVL_W-1:0]    level;
    } t_table_answer;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [OP_W-1:0]     i_operation    = OP_INSERT;
    logic [KEY_W-1:0]    i_entry_id     = '0;
    logic [LVL_W-1:0]    i_amount       = '0;
    logic                busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [KEY_W-1:0]    o_result_id;
    logic [LVL_W-1:0]    o_result_level;

    // Shadow copy of the table, updated at each accepted transaction.
    bit               live       [DEPTH];
    logic [KEY_W-1:0] live_key   [DEPTH];
    logic [LVL_W-1:0] live_level [DEPTH];
    logic [ARR_W-1:0] live_stamp [DEPTH];
    logic [ARR_W-1:0] next_stamp;

    t_table_answer    pending_answers[$];
    t_table_answer    want;
    logic [KEY_W-1:0] id_pool[POOL_SIZE];

    int idle_pct = 0;       // chance, in percent, that the sender idles before a transaction
    int error_count = 0;
    int sent_count = 0;
    int results_checked = 0;
    int op_count[4];
    int status_seen[5];

    keyed_max_priority_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_id    (o_result_id),
        .o_result_level (o_result_level)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow table helpers
    // ------------------------------------------------------------------
    function automatic int locate_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < DEPTH; i++) begin
            if (live[i] && live_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) n += live[i];
        return n;
    endfunction

    // Applies one transaction to the shadow table and returns the answer it must give.
    function automatic t_table_answer predict_table_op(input logic [OP_W-1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [LVL_W-1:0] amt);
        t_table_answer ans;
        int            s;
        int            best;
        logic [LVL_W:0] sum;
        ans = '0;
        ans.status = ST_OK;
        s = locate_key(key);
        case (op)
            OP_INSERT: begin
                if (s >= 0) begin
                    ans.status = ST_DUPLICATE;
                end else begin
                    // lowest-numbered free slot takes the new entry
                    for (int i = DEPTH - 1; i >= 0; i--) begin
                        if (!live[i]) s = i;
                    end
                    if (s < 0) begin
                        ans.status = ST_FULL;
                    end else begin
                        live[s]       = 1'b1;
                        live_key[s]   = key;
                        live_level[s] = amt;
                        live_stamp[s] = next_stamp;
                        next_stamp    = next_stamp + 1'b1;
                    end
                end
            end
            OP_INCREASE: begin
                if (s < 0) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    sum = {1'b0, live_level[s]} + {1'b0, amt};
                    live_level[s] = sum[LVL_W] ? '1 : sum[LVL_W-1:0];
                end
            end
            OP_REMOVE: begin
                if (s < 0) ans.status = ST_NOT_FOUND;
                else live[s] = 1'b0;
            end
            default: begin
                // highest level wins, earliest stamp breaks a tie
                best = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (live[i] && (best < 0 || live_level[i] > live_level[best] ||
                        (live_level[i] == live_level[best] &&
                         live_stamp[i] < live_stamp[best])))
                        best = i;
                end
                if (best < 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    ans.id    = live_key[best];
                    ans.level = live_level[best];
                end
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Random field pickers
    // ------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] random_live_key();
        int picks[$];
        for (int i = 0; i < DEPTH; i++) begin
            if (live[i]) picks = {picks, i};
        end
        if (picks.size() == 0) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return live_key[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    // live_pct: how often the id names an entry that is in the table
    function automatic logic [KEY_W-1:0] random_entry_id(input int live_pct);
        logic [KEY_W-1:0] v;
        int               r;
        r = $urandom_range(0, 99);
        if (r < live_pct && occupancy() != 0) return random_live_key();
        if (r < 90) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        v = KEY_W'($urandom);
        return v;
    endfunction

    // Small values give plenty of level ties; values near the top give saturation.
    function automatic logic [LVL_W-1:0] random_amount();
        logic [LVL_W-1:0] v;
        int               r;
        r = $urandom_range(0, 99);
        v = LVL_W'($urandom);
        if (r < 30) v = LVL_W'($urandom_range(0, 15));
        else if (r < 50) v = LVL_W'($urandom_range(16'hFFF0, 16'hFFFF));
        else if (r < 60) v = $urandom_range(0, 1) ? '1 : '0;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transaction, with an optional idle stretch ahead of it.
    // start stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [LVL_W-1:0] amt);
        t_table_answer ans;
        if ($urandom_range(0, 99) < idle_pct) begin
            repeat ($urandom_range(1, MAX_GAP)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_entry_id  <= key;
        i_amount    <= amt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ans = predict_table_op(op, key, amt);
        pending_answers = {pending_answers, ans};
        sent_count++;
        op_count[op]++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: status %0d id %h level %h",
                             $realtime, o_status, o_result_id, o_result_level);
            end else begin
                want = pending_answers.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (o_status !== want.status || o_result_id !== want.id ||
                    o_result_level !== want.level) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] mismatch: status %0d/%0d id %h/%h level %h/%h %s",
                                 $realtime, want.status, o_status, want.id, o_result_id,
                                 want.level, o_result_level, "(expected/actual)");
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Empty table: query reports empty, increase/remove find nothing.
    task automatic test_empty_table();
        issue_op(OP_QUERY, 16'h1234, 16'hABCD);
        issue_op(OP_REMOVE, 16'h0000, 16'h0000);
        issue_op(OP_INCREASE, 16'hFFFF, 16'hFFFF);
    endtask

    // Extreme ids and levels, then a rejected duplicate insert and a query.
    task automatic test_insert_and_duplicate();
        issue_op(OP_INSERT, 16'h0000, 16'h0000);
        issue_op(OP_INSERT, 16'hFFFF, 16'hFFFF);
        issue_op(OP_INSERT, 16'h0000, 16'h5555);
        issue_op(OP_QUERY, 16'hFFFF, 16'hFFFF);
    endtask

    // Increase up to exactly max, past max, by a full-scale delta and by zero.
    task automatic test_level_saturation();
        issue_op(OP_INCREASE, 16'h0000, 16'hFFFF);
        issue_op(OP_INCREASE, 16'h0000, 16'h0001);
        issue_op(OP_INCREASE, 16'hFFFF, 16'hFFFF);
        issue_op(OP_INCREASE, 16'hFFFF, 16'h0000);
        // both at max now: older arrival must win
        issue_op(OP_QUERY, 16'h0000, 16'h0000);
    endtask

    // A reused low slot holds a newer stamp: ties go by stamp, not by slot.
    task automatic test_tie_breaking();
        issue_op(OP_REMOVE, 16'h0000, 16'h1111);
        issue_op(OP_INSERT, 16'h5A5A, 16'hFFFF);
        issue_op(OP_QUERY, 16'hA5A5, 16'h0000);
        issue_op(OP_REMOVE, 16'hFFFF, 16'h0000);
        issue_op(OP_REMOVE, 16'h5A5A, 16'h0000);
        issue_op(OP_REMOVE, 16'h5A5A, 16'h0000);
        issue_op(OP_QUERY, 16'h0000, 16'h0000);
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------
    // Fill every slot with fresh ids, bounce off the full table, then drain half.
    task automatic test_capacity_limit();
        logic [KEY_W-1:0] fresh;
        while (occupancy() < DEPTH) begin
            do begin
                fresh = KEY_W'($urandom);
            end while (locate_key(fresh) >= 0);
            issue_op(OP_INSERT, fresh, random_amount());
        end
        repeat (2) begin
            do begin
                fresh = KEY_W'($urandom);
            end while (locate_key(fresh) >= 0);
            issue_op(OP_INSERT, fresh, random_amount());
        end
        // duplicate check comes before the full check
        issue_op(OP_INSERT, random_live_key(), random_amount());
        issue_op(OP_QUERY, random_entry_id(0), random_amount());
        repeat (DEPTH / 2) issue_op(OP_REMOVE, random_live_key(), random_amount());
        issue_op(OP_QUERY, random_entry_id(0), random_amount());
    endtask

    // Mixed traffic; the op mix leans toward removes as the table nears full.
    task automatic test_random_traffic(input int count);
        logic [OP_W-1:0] op;
        int              r;
        int              w_ins;
        int              w_rem;
        for (int n = 0; n < count; n++) begin
            r     = $urandom_range(0, 99);
            w_ins = (occupancy() >= DEPTH - 8) ? 15 : 40;
            w_rem = (occupancy() >= DEPTH - 8) ? 35 : 15;
            if (r < w_ins) op = OP_INSERT;
            else if (r < w_ins + 25) op = OP_INCREASE;
            else if (r < w_ins + 25 + w_rem) op = OP_REMOVE;
            else op = OP_QUERY;
            issue_op(op, random_entry_id(op == OP_INSERT ? 15 : 75), random_amount());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = KEY_W'($urandom);
        next_stamp = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // back-to-back, no idling; the clearing pass after reset shows up as busy
        idle_pct = 0;
        test_empty_table();
        test_insert_and_duplicate();
        test_level_saturation();
        test_tie_breaking();
        test_random_traffic(150);

        // mostly idle sender
        idle_pct = 82;
        test_capacity_limit();
        test_random_traffic(150);

        // occasional idling
        idle_pct = 38;
        test_random_traffic(150);

        @(negedge i_clk);
        start <= 1'b0;

        waited = 0;
        while (pending_answers.size() != 0 && waited < 4 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_answers.size() != 0) begin
            error_count += pending_answers.size();
            $display("%0d results never arrived", pending_answers.size());
        end
        // catch any stray strobe after the last expected one
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("Covered %0d transactions (insert %0d, increase %0d, remove %0d, query %0d),",
                 sent_count, op_count[OP_INSERT], op_count[OP_INCREASE],
                 op_count[OP_REMOVE], op_count[OP_QUERY]);
        $display("%0d results checked: ok %0d, empty %0d, full %0d, not found %0d, dup %0d",
                 results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_NOT_FOUND], status_seen[ST_DUPLICATE]);
        if (error_count == 0) begin
            $display("** keyed_max_priority_table: PASSED **");
        end else begin
            $display("%0d errors", error_count);
            $display("** keyed_max_priority_table: FAILED **");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #6000000;
        $display("timeout waiting for the table");
        $display("** keyed_max_priority_table: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/kmpt_pkg.sv
hdl/kmpt_ram.sv
hdl/keyed_max_priority_table.sv
hdl/kmpt_checker.sv
test/keyed_max_priority_table_tb.sv
